/* sv/lspe_pkg.sv */
// Package for the line sensor position estimator.
// Shared types, constants and the controller/datapath command and status structs.
package lspe_pkg;

	localparam int unsigned NumSensors = 8;
	localparam int unsigned RawW = 11;
	localparam int unsigned PosW = 13;
	localparam logic [10:0] FullScale = 11'd1023;
	localparam logic [9:0] CalScale = 10'd1000;
	localparam logic signed [12:0] PosMax = 13'sd3500;
	localparam logic signed [12:0] PosMin = -13'sd3500;

	// commands
	localparam logic [1:0] CmdClear = 2'd0;
	localparam logic [1:0] CmdSample = 2'd1;
	localparam logic [1:0] CmdMeasure = 2'd2;

	// register indexes
	localparam logic [0:0] RegThreshold = 1'd0;
	localparam logic [0:0] RegColor = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_ACCUM,
		ST_POS_START,
		ST_POS_RUN,
		ST_FINISH,
		ST_OUT
	} lspe_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input beat
		logic cal_clear;
		logic cal_sample;
		logic sdiv_start;   // start scaling division for current sensor
		logic accum;        // fold scaled value into sums, advance sensor
		logic pdiv_start;   // start position division
		logic finish;       // form position, update last position
	} lspe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic last_sensor;
		logic need_pdiv;
	} lspe_sts_t;

endpackage

/* sv/line_sensor_position_estimator_unit.sv */
// Top level of the line sensor position estimator.
// Joins lspe_ctrl and lspe_dp; depends on lspe_pkg.
//
// Clear and sample commands give no result. A measure command scales the
// eight sensors one after another on a shared bit-serial divider (start,
// divide, accumulate for each sensor), then divides the weighted sum once
// more (skipped when an edge sensor or no sensor sees the line) and offers
// the result beat; the next input beat can be taken in the same cycle as the
// result is offered. Only one item is in flight; the result sits in an
// output register while the next input beat is taken. Configuration writes
// are always ready.
module line_sensor_position_estimator_unit import lspe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [1:0]  command,
	input  logic [10:0] raw_0, raw_1, raw_2, raw_3, raw_4, raw_5, raw_6, raw_7,
	output logic        valid_out,
	input  logic        stall_out,
	output logic signed [12:0] position,
	output logic [7:0]  line_mask,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	lspe_cmd_t cmd;
	lspe_sts_t sts;
	logic [9:0] thr_q;
	logic color_q;
	logic [RawW-1:0] raw [NumSensors];

	assign raw = '{raw_0, raw_1, raw_2, raw_3, raw_4, raw_5, raw_6, raw_7};
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			color_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegThreshold: thr_q <= cfg_data;
				RegColor: color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lspe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_in), .in_command(command),
		.in_stall(stall_in), .out_valid(valid_out), .out_stall(stall_out),
		.cmd(cmd), .sts(sts)
	);

	lspe_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .raw(raw),
		.noise_threshold(thr_q), .line_color(color_q),
		.position(position), .line_mask(line_mask)
	);
endmodule

/* sv/lspe_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Unsigned 25-bit dividend by 21-bit divisor. Depends on lspe_pkg.
module lspe_div import lspe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [24:0] dividend,
	input  logic [20:0] divisor,
	output logic [24:0] quotient,
	output logic        done
);
	logic [24:0] quo_q;
	logic [21:0] rem_q;
	logic [20:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [21:0] trial;
	logic [21:0] shifted;

	// shift in next dividend bit and try subtract
	always_comb begin
		shifted = {rem_q[20:0], quo_q[24]};
		trial = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd24) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[21]) begin
				rem_q <= trial;
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[23:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = busy_q && (cnt_q == 5'd24);
endmodule

/* sv/lspe_ctrl.sv */
// Controller state machine for the line sensor position estimator.
// Sequences the shared divider over sensors; depends on lspe_pkg.
module lspe_ctrl import lspe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_command,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output lspe_cmd_t  cmd,
	input  lspe_sts_t  sts
);
	lspe_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && out_stall;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_command)
						CmdClear: cmd.cal_clear = 1'b1;
						CmdSample: cmd.cal_sample = 1'b1;
						CmdMeasure: state_d = ST_DIV_START;
						default: ;
					endcase
				end
			end
			ST_DIV_START: begin
				cmd.sdiv_start = 1'b1;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: if (sts.div_done) state_d = ST_ACCUM;
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d = sts.last_sensor ? ST_POS_START : ST_DIV_START;
			end
			ST_POS_START: begin
				if (sts.need_pdiv) begin
					cmd.pdiv_start = 1'b1;
					state_d = ST_POS_RUN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_POS_RUN: if (sts.div_done) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: begin
				// wait until output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

/* sv/lspe_dp.sv */
// Datapath: calibration window, scaling, threshold sums and position.
// Uses lspe_div for all divisions; depends on lspe_pkg.
module lspe_dp import lspe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lspe_cmd_t           cmd,
	output lspe_sts_t           sts,
	input  logic [RawW-1:0]     raw [NumSensors],
	input  logic [9:0]          noise_threshold,
	input  logic                line_color,
	output logic signed [PosW-1:0] position,
	output logic [7:0]          line_mask
);
	logic [RawW-1:0] rd_q [NumSensors];
	logic [RawW-1:0] min_q [NumSensors];
	logic [RawW-1:0] max_q [NumSensors];
	logic [2:0]  sel_q;
	logic [7:0]  mask_q;
	logic [13:0] sum_q;      // up to 8*1023
	logic [24:0] wsum_q;     // up to 28*1023*1000, needs 25b
	logic signed [PosW-1:0] last_q;
	logic signed [PosW-1:0] pos_q;
	logic [7:0]  omask_q;
	logic        div_start;
	logic [24:0] div_dividend;
	logic [20:0] div_divisor;
	logic [24:0] div_quo;
	logic        div_done;
	logic        pdiv_q;

	// current sensor scaling operands
	logic [RawW-1:0] cur_rd, cur_lo, cur_hi;
	logic signed [11:0] num_diff, span;
	logic        neg_q, zero_q, ovr_neg;
	logic [11:0] abs_num, abs_span;
	logic [21:0] num_prod;
	logic [10:0] scaled, vval;
	logic        on_line;
	logic [23:0] wterm;

	always_comb begin
		cur_rd = rd_q[sel_q];
		cur_lo = min_q[sel_q];
		cur_hi = max_q[sel_q];
		num_diff = $signed({1'b0, cur_rd}) - $signed({1'b0, cur_lo});
		span = $signed({1'b0, cur_hi}) - $signed({1'b0, cur_lo});
		abs_num = num_diff[11] ? 12'(-num_diff) : 12'(num_diff);
		abs_span = span[11] ? 12'(-span) : 12'(span);
		num_prod = 22'(abs_num) * 22'(CalScale);
	end

	// sign and zero-span flags latched at division start
	always_ff @(posedge clk) begin
		if (cmd.sdiv_start) begin
			neg_q <= (num_diff[11] ^ span[11]) && (num_diff != 0);
			zero_q <= (span == 0);
		end
	end

	// quotient clamp: negative or zero span -> 0, above scale -> scale
	assign ovr_neg = neg_q;
	always_comb begin
		if (zero_q || ovr_neg) scaled = '0;
		else if (div_quo > 25'(CalScale)) scaled = 11'(CalScale);
		else scaled = div_quo[10:0];
		vval = line_color ? (FullScale - scaled) : scaled;
		on_line = vval > {1'b0, noise_threshold};
		wterm = 24'(vval) * 24'(sel_q) * 24'(CalScale);
	end

	always_comb begin
		div_start = cmd.sdiv_start || cmd.pdiv_start;
		if (cmd.pdiv_start) begin
			div_dividend = wsum_q;
			div_divisor = 21'(sum_q);
		end else begin
			div_dividend = 25'(num_prod);
			div_divisor = 21'(abs_span);
		end
	end

	lspe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(div_divisor),
		.quotient(div_quo), .done(div_done)
	);

	// calibration window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSensors; i++) begin
				min_q[i] <= '0;
				max_q[i] <= FullScale;
			end
		end else if (cmd.cal_clear) begin
			for (int i = 0; i < NumSensors; i++) begin
				min_q[i] <= FullScale;
				max_q[i] <= '0;
			end
		end else if (cmd.cal_sample) begin
			for (int i = 0; i < NumSensors; i++) begin
				if (raw[i] > max_q[i]) max_q[i] <= raw[i];
				if (raw[i] < min_q[i]) min_q[i] <= raw[i];
			end
		end
	end

	// input capture and per-sensor accumulation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= raw;
			sel_q <= '0;
			mask_q <= '0;
			sum_q <= '0;
			wsum_q <= '0;
		end else if (cmd.accum) begin
			sel_q <= sel_q + 3'd1;
			if (on_line) begin
				mask_q[sel_q] <= 1'b1;
				sum_q <= sum_q + 14'(vval);
				wsum_q <= wsum_q + 25'(wterm);
			end
		end
		if (cmd.pdiv_start) pdiv_q <= 1'b1;
		else if (cmd.load) pdiv_q <= 1'b0;
	end

	// final position and last-position memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.finish) begin
			last_q <= pos_q;
		end
	end

	logic signed [PosW-1:0] pos_d;
	always_comb begin
		if (mask_q == 8'd0) pos_d = (last_q < 0) ? PosMin : PosMax;
		else if (mask_q[0]) pos_d = PosMin;
		else if (mask_q[7]) pos_d = PosMax;
		else if (pdiv_q) pos_d = $signed(PosW'(div_quo)) - PosMax;
		else pos_d = PosMin;
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (cmd.finish) begin
			position <= pos_q;
			omask_q <= mask_q;
		end
	end

	assign line_mask = omask_q;
	assign sts.div_done = div_done;
	assign sts.last_sensor = (sel_q == 3'd7);
	assign sts.need_pdiv = (mask_q != 0) && !mask_q[0] && !mask_q[7] && (sum_q != 0);
endmodule
